// ===== sv/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and codes for the ordered list engine: command and status
// codes, controller states, and the command/status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package ole_pkg;

   // request command codes
   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_END   = 3'd1,
      CMD_INS_POS   = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_END   = 3'd4,
      CMD_DEL_VAL   = 3'd5,
      CMD_READ      = 3'd6,
      CMD_COUNT     = 3'd7
   } cmd_type;

   // response status codes
   typedef enum logic [2:0] {
      ST_DONE   = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_NO_POS = 3'd2,
      ST_NO_VAL = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   // read out stops after this many elements
   localparam int MAX_READ = 32;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_PUSH,
      S_CAPF,
      S_WALK,
      S_APPEND,
      S_GIVE,
      S_RESP
   } state_type;

   // store read address source
   typedef enum logic [1:0] {
      RD_HOLD,
      RD_HEAD,
      RD_FREE,
      RD_LINK
   } rsel_type;

   // store update operations
   typedef enum logic [2:0] {
      W_NONE,
      W_PUSH_FRONT,
      W_LINK_NEW,
      W_APPEND,
      W_UNLINK_HEAD,
      W_BYPASS,
      W_GIVE_CUR
   } wop_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      rsel_type   rsel;
      logic       cap_free;
      wop_type    wop;
      logic       emit;
      status_type emit_st;
      logic       emit_val;
      logic       emit_last;
   } ole_ctl_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    pos_bad;
      logic    at_end;
      logic    idx_zero;
      logic    match;
      logic    out_free;
   } ole_sts_type;

endpackage

// ===== sv/ole_ctrl.sv =====
// ----------------------------------------------------------------------------
// ole_ctrl
// Sequencer for the ordered list engine: checks each request, steers the
// list walk one node per unstalled cycle, issues store updates and responses.
// ----------------------------------------------------------------------------
module ole_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ole_pkg::ole_sts_type sts,
   output ole_pkg::ole_ctl_type ctl
);
   import ole_pkg::*;

   state_type  state_ff, state_in;
   status_type st_ff, st_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_DONE;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

   // next state and pending status
   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            st_in    = ST_DONE;
            state_in = S_RESP;
            case (sts.cmd) inside
               CMD_INS_FRONT: begin
                  if (sts.full) st_in = ST_FULL;
                  else state_in = S_PUSH;
               end
               CMD_INS_END: begin
                  if (sts.full) st_in = ST_FULL;
                  else if (sts.empty) state_in = S_PUSH;
                  else state_in = S_CAPF;
               end
               CMD_INS_POS: begin
                  if (sts.full) st_in = ST_FULL;
                  else if (sts.pos_bad) st_in = ST_NO_POS;
                  else state_in = S_CAPF;
               end
               CMD_DEL_FRONT, CMD_DEL_END: begin
                  if (sts.empty) st_in = ST_EMPTY;
                  else state_in = S_WALK;
               end
               CMD_DEL_VAL: begin
                  if (sts.empty) st_in = ST_NO_VAL;
                  else state_in = S_WALK;
               end
               CMD_READ: begin
                  if (sts.empty) st_in = ST_EMPTY;
                  else state_in = S_WALK;
               end
               default: ;
            endcase
         end
         S_PUSH: state_in = S_RESP;
         S_CAPF: state_in = S_WALK;
         S_WALK: begin
            case (sts.cmd) inside
               CMD_INS_END, CMD_INS_POS: begin
                  if (sts.at_end) state_in = S_APPEND;
               end
               CMD_DEL_FRONT: state_in = S_RESP;
               CMD_DEL_END: begin
                  if (sts.at_end) state_in = S_RESP;
               end
               CMD_DEL_VAL: begin
                  if (sts.match) begin
                     state_in = sts.idx_zero ? S_RESP : S_GIVE;
                  end else if (sts.at_end) begin
                     st_in    = ST_NO_VAL;
                     state_in = S_RESP;
                  end
               end
               CMD_READ: begin
                  if (sts.out_free && sts.at_end) state_in = S_IDLE;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_APPEND: state_in = S_RESP;
         S_GIVE:   state_in = S_RESP;
         S_RESP: begin
            if (sts.out_free) state_in = S_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      ctl         = '0;
      ctl.rsel    = RD_HOLD;
      ctl.wop     = W_NONE;
      ctl.emit_st = st_ff;
      req_stall   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            ctl.load  = req_valid;
         end
         S_DISPATCH: begin
            case (sts.cmd) inside
               CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS: ctl.rsel = RD_FREE;
               CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_VAL, CMD_READ: ctl.rsel = RD_HEAD;
               default: ;
            endcase
         end
         S_PUSH: ctl.wop = W_PUSH_FRONT;
         S_CAPF: begin
            ctl.cap_free = 1'b1;
            ctl.rsel     = RD_HEAD;
         end
         S_WALK: begin
            case (sts.cmd) inside
               CMD_INS_END, CMD_INS_POS: begin
                  if (sts.at_end) ctl.wop = W_LINK_NEW;
                  else ctl.rsel = RD_LINK;
               end
               CMD_DEL_FRONT: ctl.wop = W_UNLINK_HEAD;
               CMD_DEL_END: begin
                  if (sts.at_end) ctl.wop = W_GIVE_CUR;
                  else ctl.rsel = RD_LINK;
               end
               CMD_DEL_VAL: begin
                  if (sts.match) ctl.wop = sts.idx_zero ? W_UNLINK_HEAD : W_BYPASS;
                  else if (!sts.at_end) ctl.rsel = RD_LINK;
               end
               CMD_READ: begin
                  if (sts.out_free) begin
                     ctl.emit      = 1'b1;
                     ctl.emit_st   = ST_DONE;
                     ctl.emit_val  = 1'b1;
                     ctl.emit_last = sts.at_end;
                     if (!sts.at_end) ctl.rsel = RD_LINK;
                  end
               end
               default: ;
            endcase
         end
         S_APPEND: ctl.wop = W_APPEND;
         S_GIVE:   ctl.wop = W_GIVE_CUR;
         S_RESP: begin
            ctl.emit      = sts.out_free;
            ctl.emit_last = 1'b1;
         end
      endcase
   end

endmodule

// ===== sv/ole_dp.sv =====
// ----------------------------------------------------------------------------
// ole_dp
// Datapath of the ordered list engine: value and link stores with registered
// reads, head/free/count registers, walk index, and the response register.
// ----------------------------------------------------------------------------
module ole_dp #(
   parameter int CAPACITY   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           req_cmd,
   input  logic signed [31:0]   req_item_value,
   input  logic [5:0]           req_position,
   input  ole_pkg::ole_ctl_type ctl,
   output ole_pkg::ole_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic signed [31:0]   rsp_out_value,
   output logic [5:0]           rsp_node_total,
   output logic                 rsp_last
);
   import ole_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 6) ? CW : 6;
   localparam int DW = DATA_WIDTH;

   // stores
   logic [IW-1:0] link_mem [CAPACITY];
   logic [DW-1:0] val_mem  [CAPACITY];
   logic [CAPACITY-1:0] lvalid_ff;

   logic [IW-1:0] head_ff, head_in, free_ff, free_in, fnext_ff;
   logic [CW-1:0] count_ff, count_in, idx_ff;
   logic [IW-1:0] prev_ff, addr_ff, lm_ff, raddr, lnk_rd;
   logic [DW-1:0] vm_ff, val_ff;
   logic          lv_rd_ff;
   cmd_type       cmd_ff;
   logic [5:0]    pos_ff;

   logic          lw_en, vw_en;
   logic [IW-1:0] lw_addr, lw_data;

   logic [DW+31:0]        vin_ext;
   logic signed [DW+31:0] vout_ext;
   logic [CW+5:0]         nt_ext;
   logic [XW-1:0]         count_x, posc_x, lim_x, tgt_x;

   logic               rsp_valid_ff, out_free;
   status_type         rsp_status_ff;
   logic signed [31:0] rsp_value_ff;
   logic [5:0]         rsp_total_ff;
   logic               rsp_last_ff;

   // width conversions of stored values
   assign vin_ext  = (DW + 32)'($unsigned(req_item_value));
   assign vout_ext = (DW + 32)'(signed'(vm_ff));
   assign nt_ext   = (CW + 6)'(count_ff);

   // link of the node just read; unwritten entries chain to the next entry
   assign lnk_rd = lv_rd_ff ? lm_ff
                 : ((addr_ff == IW'(CAPACITY - 1)) ? '0 : addr_ff + 1'b1);

   // read address select
   always_comb begin
      unique case (ctl.rsel)
         RD_HOLD: raddr = addr_ff;
         RD_HEAD: raddr = head_ff;
         RD_FREE: raddr = free_ff;
         RD_LINK: raddr = lnk_rd;
      endcase
   end

   // store updates and list pointer next values
   always_comb begin
      lw_en    = 1'b0;
      vw_en    = 1'b0;
      lw_addr  = addr_ff;
      lw_data  = free_ff;
      head_in  = head_ff;
      free_in  = free_ff;
      count_in = count_ff;
      unique case (ctl.wop)
         W_NONE: ;
         W_PUSH_FRONT: begin
            lw_en    = 1'b1;
            vw_en    = 1'b1;
            lw_addr  = free_ff;
            lw_data  = head_ff;
            head_in  = free_ff;
            free_in  = lnk_rd;
            count_in = count_ff + 1'b1;
         end
         W_LINK_NEW: begin
            lw_en   = 1'b1;
            vw_en   = 1'b1;
            lw_addr = free_ff;
            lw_data = lnk_rd;
         end
         W_APPEND: begin
            lw_en    = 1'b1;
            free_in  = fnext_ff;
            count_in = count_ff + 1'b1;
         end
         W_UNLINK_HEAD: begin
            lw_en    = 1'b1;
            head_in  = lnk_rd;
            free_in  = addr_ff;
            count_in = count_ff - 1'b1;
         end
         W_BYPASS: begin
            lw_en   = 1'b1;
            lw_addr = prev_ff;
            lw_data = lnk_rd;
         end
         W_GIVE_CUR: begin
            lw_en    = 1'b1;
            free_in  = addr_ff;
            count_in = count_ff - 1'b1;
         end
         default: ;
      endcase
   end

   // memories with registered read
   always_ff @(posedge clock) begin
      if (lw_en) link_mem[lw_addr] <= lw_data;
      if (vw_en) val_mem[free_ff] <= val_ff;
      lm_ff    <= link_mem[raddr];
      vm_ff    <= val_mem[raddr];
      lv_rd_ff <= lvalid_ff[raddr];
      addr_ff  <= raddr;
   end

   // list control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         free_ff   <= '0;
         count_ff  <= '0;
         lvalid_ff <= '0;
      end else begin
         head_ff  <= head_in;
         free_ff  <= free_in;
         count_ff <= count_in;
         if (lw_en) lvalid_ff[lw_addr] <= 1'b1;
      end
   end

   // request capture, walk index, free-list successor
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= cmd_type'(req_cmd);
         val_ff <= vin_ext[DW-1:0];
         pos_ff <= req_position;
      end
      if (ctl.cap_free) fnext_ff <= lnk_rd;
      if (ctl.rsel == RD_HEAD) begin
         idx_ff <= '0;
      end else if (ctl.rsel == RD_LINK) begin
         idx_ff  <= idx_ff + 1'b1;
         prev_ff <= addr_ff;
      end
   end

   // walk targets
   assign count_x = XW'(count_ff);
   assign posc_x  = (pos_ff <= 6'd1) ? '0 : XW'(pos_ff) - 1'b1;
   assign lim_x   = (count_x < XW'(MAX_READ)) ? count_x : XW'(MAX_READ);

   always_comb begin
      case (cmd_ff)
         CMD_INS_POS: tgt_x = posc_x;
         CMD_READ:    tgt_x = lim_x - 1'b1;
         default:     tgt_x = count_x - 1'b1;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // status to the controller
   always_comb begin
      sts.cmd      = cmd_ff;
      sts.full     = (count_ff == CW'(CAPACITY));
      sts.empty    = (count_ff == '0);
      sts.pos_bad  = (posc_x >= count_x);
      sts.at_end   = (idx_ff == tgt_x[CW-1:0]);
      sts.idx_zero = (idx_ff == '0);
      sts.match    = (vm_ff == val_ff);
      sts.out_free = out_free;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_status_ff <= ctl.emit_st;
         rsp_value_ff  <= ctl.emit_val ? vout_ext[31:0] : '0;
         rsp_total_ff  <= nt_ext[5:0];
         rsp_last_ff   <= ctl.emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_node_total = rsp_total_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== sv/ordered_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Ordered list of signed words in a linked store with a free list.
// ----------------------------------------------------------------------------
// One request is handled at a time; the link store is read one node per
// cycle while the response side keeps up, so a request's duration follows
// its walk length: count and the error answers go straight to the response,
// insert front and delete front touch only the head, while insert end,
// positional insert, delete end and delete value walk the list at a pace
// set by the single read port of the link store. Read out returns one element per
// cycle while the response side keeps up. A new request is taken while the
// last response still waits in the output register.
module ordered_list_engine_core #(
   parameter int CAPACITY   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_item_value,
   input  logic [5:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_out_value,
   output logic [5:0]         rsp_node_total,
   output logic               rsp_last
);
   import ole_pkg::*;

   ole_ctl_type ctl;
   ole_sts_type sts;

   // sequencer
   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // stores and response register
   ole_dp #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_cmd),
      .req_item_value (req_item_value),
      .req_position   (req_position),
      .ctl            (ctl),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_node_total (rsp_node_total),
      .rsp_last       (rsp_last)
   );

   // a taken request keeps the input closed for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // a response is only written when the output register has room
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> sts.out_free)
      else $error("response overwritten");

   // the final response of a request frees the input
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      ctl.emit && ctl.emit_last |=> !req_stall)
      else $error("input not reopened after final response");

endmodule
